[sv/uitf_pkg.sv]
// Package for the UART idle-timeout framer: shared types, codes and constants.
// No dependencies.
`timescale 1ns / 1ps

package uitf_pkg;

  localparam int unsigned BUFFER_SIZE_DEF = 64;
  localparam int unsigned LEN_W           = 6;
  localparam int unsigned BYTE_W          = 8;
  localparam int unsigned TICK_W          = 8;

  localparam int unsigned APB_AW          = 2;
  localparam int unsigned APB_DW          = 32;
  localparam logic [APB_AW-1:0] REG_IDLE_TIMEOUT_ADDR = 2'd0;
  localparam logic [TICK_W-1:0] IDLE_TIMEOUT_RST      = 8'd10;

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QUEUE_PW    = $clog2(QUEUE_DEPTH);
  localparam int unsigned QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic {
    OP_BYTE = 1'b0,
    OP_TICK = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_READ,
    BK_SEND
  } back_state_e;

  // closed frame waiting for readout
  typedef struct packed {
    logic             bank;
    logic [LEN_W-1:0] len;
    logic             full;
  } frame_desc_t;

  // back side hands a buffer bank back to the front side
  typedef struct packed {
    logic valid;
    logic bank;
  } bank_release_t;

endpackage

[sv/uitf_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module uitf_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[sv/uitf_front.sv]
// Front side: accepts bytes and ticks, fills the frame buffer, closes frames.
// Depends on uitf_pkg.
`timescale 1ns / 1ps

module uitf_front #(
  parameter int unsigned BUFFER_SIZE = uitf_pkg::BUFFER_SIZE_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic                                  operation_i,
  input  logic [uitf_pkg::BYTE_W-1:0]           rx_byte_i,
  input  logic [uitf_pkg::TICK_W-1:0]           idle_timeout_i,
  output logic                                  ram_we_o,
  output logic [$clog2(BUFFER_SIZE):0]          ram_waddr_o,
  output logic [uitf_pkg::BYTE_W-1:0]           ram_wdata_o,
  output logic                                  push_o,
  output uitf_pkg::frame_desc_t                 desc_o,
  input  uitf_pkg::bank_release_t               rel_i
);

  import uitf_pkg::*;

  localparam int unsigned IW = $clog2(BUFFER_SIZE);
  localparam logic [LEN_W-1:0] FULL_LEVEL = LEN_W'(BUFFER_SIZE - 1);

  logic [LEN_W-1:0]  fill_q, fill_d, fill_inc;
  logic              open_q, open_d;
  logic [TICK_W-1:0] idle_q, idle_d, idle_inc;
  logic              bank_q, bank_d;
  logic [1:0]        busy_q, busy_d;
  logic              accept, close;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
      open_q <= 1'b0;
      idle_q <= '0;
      bank_q <= 1'b0;
      busy_q <= '0;
    end else begin
      fill_q <= fill_d;
      open_q <= open_d;
      idle_q <= idle_d;
      bank_q <= bank_d;
      busy_q <= busy_d;
    end
  end

  assign in_ready_o  = !busy_q[bank_q];
  assign accept      = in_valid_i && in_ready_o;
  assign fill_inc    = fill_q + LEN_W'(1);
  assign idle_inc    = (idle_q == '1) ? idle_q : idle_q + TICK_W'(1);
  assign ram_waddr_o = {bank_q, fill_q[IW-1:0]};
  assign ram_wdata_o = rx_byte_i;

  always_comb begin
    fill_d      = fill_q;
    open_d      = open_q;
    idle_d      = idle_q;
    bank_d      = bank_q;
    busy_d      = busy_q;
    ram_we_o    = 1'b0;
    close       = 1'b0;
    desc_o.bank = bank_q;
    desc_o.len  = fill_q;
    desc_o.full = 1'b0;

    if (accept) begin
      if (operation_i == OP_BYTE) begin
        ram_we_o = 1'b1;
        open_d   = 1'b1;
        idle_d   = '0;
        fill_d   = fill_inc;
        if (fill_inc >= FULL_LEVEL) begin
          close       = 1'b1;
          desc_o.len  = fill_inc;
          desc_o.full = 1'b1;
        end
      end else if (open_q) begin
        idle_d = idle_inc;
        if (idle_inc > idle_timeout_i) begin
          close = 1'b1;
        end
      end
    end

    if (rel_i.valid) begin
      busy_d[rel_i.bank] = 1'b0;
    end

    if (close) begin
      fill_d         = '0;
      open_d         = 1'b0;
      idle_d         = '0;
      busy_d[bank_q] = 1'b1;
      bank_d         = !bank_q;
    end
  end

  assign push_o = close;

endmodule

[sv/uitf_fifo.sv]
// Short queue of closed-frame descriptors between front and back sides.
// Depends on uitf_pkg.
`timescale 1ns / 1ps

module uitf_fifo (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  uitf_pkg::frame_desc_t desc_i,
  input  logic                  pop_i,
  output uitf_pkg::frame_desc_t desc_o,
  output logic                  empty_o
);

  import uitf_pkg::*;

  frame_desc_t         slot_q [QUEUE_DEPTH];
  logic [QUEUE_PW-1:0] wptr_q, rptr_q;
  logic [QUEUE_CW-1:0] count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= wptr_q + QUEUE_PW'(1);
      end
      if (pop_i) begin
        rptr_q <= rptr_q + QUEUE_PW'(1);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + QUEUE_CW'(1);
      end else if (!push_i && pop_i) begin
        count_q <= count_q - QUEUE_CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wptr_q] <= desc_i;
    end
  end

  assign desc_o  = slot_q[rptr_q];
  assign empty_o = (count_q == '0);

endmodule

[sv/uitf_back.sv]
// Back side: reads a closed frame out of the buffer and sends it byte by byte.
// Depends on uitf_pkg.
`timescale 1ns / 1ps

module uitf_back #(
  parameter int unsigned BUFFER_SIZE = uitf_pkg::BUFFER_SIZE_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           empty_i,
  input  uitf_pkg::frame_desc_t          desc_i,
  output logic                           pop_o,
  output logic                           ram_re_o,
  output logic [$clog2(BUFFER_SIZE):0]   ram_raddr_o,
  input  logic [uitf_pkg::BYTE_W-1:0]    ram_rdata_i,
  output uitf_pkg::bank_release_t        rel_o,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [uitf_pkg::BYTE_W-1:0]    data_byte_o,
  output logic                           last_o,
  output logic                           closed_by_full_o,
  output logic [uitf_pkg::LEN_W-1:0]     frame_length_o
);

  import uitf_pkg::*;

  localparam int unsigned IW = $clog2(BUFFER_SIZE);

  back_state_e      state_q, state_d;
  frame_desc_t      desc_q, desc_d;
  logic [LEN_W-1:0] idx_q, idx_d;
  logic             is_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BK_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    desc_q <= desc_d;
    idx_q  <= idx_d;
  end

  assign is_last = (idx_q == desc_q.len - LEN_W'(1));

  always_comb begin
    state_d     = state_q;
    desc_d      = desc_q;
    idx_d       = idx_q;
    pop_o       = 1'b0;
    ram_re_o    = 1'b0;
    rel_o       = '0;
    out_valid_o = 1'b0;
    case (state_q)
      BK_IDLE: begin
        if (!empty_i) begin
          pop_o   = 1'b1;
          desc_d  = desc_i;
          idx_d   = '0;
          state_d = BK_READ;
        end
      end
      BK_READ: begin
        ram_re_o = 1'b1;
        state_d  = BK_SEND;
      end
      BK_SEND: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          if (is_last) begin
            rel_o.valid = 1'b1;
            rel_o.bank  = desc_q.bank;
            state_d     = BK_IDLE;
          end else begin
            idx_d   = idx_q + LEN_W'(1);
            state_d = BK_READ;
          end
        end
      end
      default: begin
        state_d = BK_IDLE;
      end
    endcase
  end

  assign ram_raddr_o      = {desc_q.bank, idx_q[IW-1:0]};
  assign data_byte_o      = ram_rdata_i;
  assign last_o           = is_last;
  assign closed_by_full_o = desc_q.full;
  assign frame_length_o   = desc_q.len;

endmodule

[sv/uart_idle_timeout_framer_core.sv]
// Top level of the UART idle-timeout framer: config register, buffer RAM,
// front side, descriptor queue and back side. Depends on uitf_pkg and all uitf_* modules.
`timescale 1ns / 1ps

// Usage
//   Input channel (in_valid_i/in_ready_o): operation_i = 0 carries a received
//   byte in rx_byte_i, operation_i = 1 is a millisecond tick. One transfer per
//   cycle is taken while the buffer bank being filled is free.
//   Output channel (out_valid_o/out_ready_i): one transfer per frame byte,
//   with last_o, closed_by_full_o and frame_length_o.
//   The buffer RAM has two banks: one fills while the other is read out.
//   in_ready_o drops only when both banks hold closed frames not yet sent.
//   When the back side is idle, the first byte of a frame becomes valid after
//   the descriptor queue entry, the BK_IDLE pop and the BK_READ RAM read.
//   Each byte is read out by a RAM read in BK_READ and then sent in BK_SEND;
//   the back side takes the next frame only after the last byte is sent.
//   A stalled receiver holds the current byte; the front keeps filling the
//   other bank meanwhile.
//   Reset clears the frame state and sets idle_timeout to 10; the RAM is not
//   cleared. idle_timeout is at APB address 0.

module uart_idle_timeout_framer_core #(
  parameter int unsigned BUFFER_SIZE = uitf_pkg::BUFFER_SIZE_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [uitf_pkg::APB_AW-1:0]   paddr,
  input  logic [uitf_pkg::APB_DW-1:0]   pwdata,
  output logic [uitf_pkg::APB_DW-1:0]   prdata,
  output logic                          pready,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          operation_i,
  input  logic [uitf_pkg::BYTE_W-1:0]   rx_byte_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [uitf_pkg::BYTE_W-1:0]   data_byte_o,
  output logic                          last_o,
  output logic                          closed_by_full_o,
  output logic [uitf_pkg::LEN_W-1:0]    frame_length_o
);

  import uitf_pkg::*;

  localparam int unsigned AW        = $clog2(BUFFER_SIZE) + 1;
  localparam int unsigned RAM_DEPTH = 2 ** AW;

  logic [TICK_W-1:0] timeout_q;
  logic              cfg_wr;

  logic              ram_we, ram_re;
  logic [AW-1:0]     ram_waddr, ram_raddr;
  logic [BYTE_W-1:0] ram_wdata, ram_rdata;
  logic              push, pop, empty;
  frame_desc_t       desc_in, desc_out;
  bank_release_t     rel;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr == REG_IDLE_TIMEOUT_ADDR);
  assign prdata = (paddr == REG_IDLE_TIMEOUT_ADDR) ? APB_DW'(timeout_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= IDLE_TIMEOUT_RST;
    end else if (cfg_wr) begin
      timeout_q <= pwdata[TICK_W-1:0];
    end
  end

  uitf_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (RAM_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  uitf_front #(
    .BUFFER_SIZE (BUFFER_SIZE)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .operation_i    (operation_i),
    .rx_byte_i      (rx_byte_i),
    .idle_timeout_i (timeout_q),
    .ram_we_o       (ram_we),
    .ram_waddr_o    (ram_waddr),
    .ram_wdata_o    (ram_wdata),
    .push_o         (push),
    .desc_o         (desc_in),
    .rel_i          (rel)
  );

  uitf_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .desc_i  (desc_in),
    .pop_i   (pop),
    .desc_o  (desc_out),
    .empty_o (empty)
  );

  uitf_back #(
    .BUFFER_SIZE (BUFFER_SIZE)
  ) u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .empty_i          (empty),
    .desc_i           (desc_out),
    .pop_o            (pop),
    .ram_re_o         (ram_re),
    .ram_raddr_o      (ram_raddr),
    .ram_rdata_i      (ram_rdata),
    .rel_o            (rel),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .data_byte_o      (data_byte_o),
    .last_o           (last_o),
    .closed_by_full_o (closed_by_full_o),
    .frame_length_o   (frame_length_o)
  );

endmodule
